// ===== hw/rtl/lru_page_replacement_top_defines.svh =====
// Assertion shorthands for the LRU page replacement block.
`ifndef LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH

// same-cycle implication, off while in reset
`define LRUPR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define LRUPR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lrupr_pkg.sv =====
package lrupr_pkg;

    localparam int FRAMES      = 16;
    localparam int PAGE_BITS   = 16;
    localparam int COUNT_W     = 32;
    localparam int CFG_W       = 5;
    localparam int FRAME_IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W      = FRAME_IDX_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

    localparam int IN_TDATA_W   = ((PAGE_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = FRAME_IDX_W + 1 + PAGE_BITS + COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    // per-frame verdict of the shared compare unit
    typedef struct packed {
        logic match;   // valid frame holding the referenced page
        logic empty;   // frame holds no page
        logic better;  // older than the best candidate so far
    } cmp_t;

endpackage

// ===== hw/rtl/lrupr_cmp_unit.sv =====
module lrupr_cmp_unit
    import lrupr_pkg::*;
(
    input  logic [PAGE_BITS-1:0] ref_page,
    input  logic [PAGE_BITS-1:0] frame_page,
    input  logic                 frame_valid,
    input  logic [RANK_W-1:0]    frame_rank,
    input  logic [RANK_W-1:0]    best_rank,
    input  logic                 first_frame,
    output cmp_t                 result
);

    always_comb begin
        result.match  = frame_valid && (frame_page == ref_page);
        result.empty  = !frame_valid;
        // strict compare: on a tie the lower index stays
        result.better = first_frame || (frame_rank > best_rank);
    end

endmodule

// ===== hw/rtl/lru_page_replacement_top.sv =====
// LRU page replacement, one page reference per word.
// Per word: accept in IDLE, scan the frames in SCAN, then commit the result in UPDATE;
// the scan stops at the first hit, a fault scans all active frames.
// A new word is accepted only after the last one is committed; UPDATE waits while the output is full.
// The scan uses the single page/rank comparator stepped over the frames, one frame per cycle.
// Reset (aresetn low, synchronous): frames empty, ranks and fault count zero, frames_in_use 4.
`include "lru_page_replacement_top_defines.svh"

module lru_page_replacement_top
    import lrupr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration: frames_in_use
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data,     // [4:0] frames_in_use
    // reference words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,      // [15:0] page_number
    input  logic                   s_tlast,      // last_reference
    // result words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,      // [3:0] frame_index, [4] evicted_valid,
                                                 // [20:5] evicted_page, [52:21] fault_count,
                                                 // [55:53] zero
    output logic                   m_tuser,      // is_fault
    output logic                   m_tlast       // final_res
);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    state_t state_reg, state_next;

    logic [CFG_W-1:0]       frames_in_use_reg;
    logic [FRAME_IDX_W-1:0] last_idx;          // highest active frame

    // frame store: page is meaningful only while the valid bit is set
    logic [PAGE_BITS-1:0]   page_mem [FRAMES];
    logic [FRAMES-1:0]      valid_reg, valid_next;
    logic [RANK_W-1:0]      rank_reg  [FRAMES];
    logic [RANK_W-1:0]      rank_next [FRAMES];
    logic [COUNT_W-1:0]     fault_total_reg, fault_total_next;

    // current reference and scan results
    logic [PAGE_BITS-1:0]   page_reg;
    logic                   last_reg;
    logic [FRAME_IDX_W-1:0] idx_reg;
    logic                   hit_reg;
    logic [FRAME_IDX_W-1:0] hit_idx_reg;
    logic [RANK_W-1:0]      hit_rank_reg;
    logic                   empty_reg;
    logic [FRAME_IDX_W-1:0] empty_idx_reg;
    logic [FRAME_IDX_W-1:0] lru_idx_reg;
    logic [RANK_W-1:0]      lru_rank_reg;
    logic [PAGE_BITS-1:0]   lru_page_reg;

    // output register
    logic                   out_valid_reg;
    logic                   out_fault_reg;
    logic [FRAME_IDX_W-1:0] out_idx_reg;
    logic                   out_ev_valid_reg;
    logic [PAGE_BITS-1:0]   out_ev_page_reg;
    logic [COUNT_W-1:0]     out_count_reg;
    logic                   out_last_reg;

    // control
    logic                   accept;
    logic                   scan_en;
    logic                   commit;
    logic                   scan_done;
    cmp_t                   cmp;

    // update-cycle decode
    logic                   is_fault;
    logic                   evict;
    logic                   age_all;
    logic [FRAME_IDX_W-1:0] f_idx;
    logic [RANK_W-1:0]      f_rank;

    // ---------------------------------------------------------------
    // Active frame count: 0 acts as 1, above FRAMES acts as FRAMES
    // ---------------------------------------------------------------
    always_comb begin
        priority if (frames_in_use_reg == '0) begin
            last_idx = '0;
        end else if (frames_in_use_reg > CFG_W'(FRAMES)) begin
            last_idx = FRAME_IDX_W'(FRAMES - 1);
        end else begin
            last_idx = FRAME_IDX_W'(frames_in_use_reg - CFG_W'(1));
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_in_use_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            frames_in_use_reg <= cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // Shared comparator, stepped over the frames
    // ---------------------------------------------------------------
    lrupr_cmp_unit u_cmp (
        .ref_page    (page_reg),
        .frame_page  (page_mem[idx_reg]),
        .frame_valid (valid_reg[idx_reg]),
        .frame_rank  (rank_reg[idx_reg]),
        .best_rank   (lru_rank_reg),
        .first_frame (idx_reg == '0),
        .result      (cmp)
    );

    assign scan_done = cmp.match || (idx_reg == last_idx);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        scan_en  = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_SCAN:   scan_en  = 1'b1;
            ST_UPDATE: commit   = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // Scan registers: first hit, first empty frame, oldest frame
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg   <= 1'b0;
            empty_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (accept) begin
            hit_reg   <= 1'b0;
            empty_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (scan_en) begin
            idx_reg <= idx_reg + FRAME_IDX_W'(1);
            if (cmp.match) begin
                hit_reg <= 1'b1;
            end
            if (cmp.empty && !empty_reg) begin
                empty_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            page_reg <= s_tdata[PAGE_BITS-1:0];
            last_reg <= s_tlast;
        end
        if (scan_en) begin
            if (cmp.match) begin
                hit_idx_reg  <= idx_reg;
                hit_rank_reg <= rank_reg[idx_reg];
            end
            if (cmp.empty && !empty_reg) begin
                empty_idx_reg <= idx_reg;
            end
            if (cmp.better) begin
                lru_idx_reg  <= idx_reg;
                lru_rank_reg <= rank_reg[idx_reg];
                lru_page_reg <= page_mem[idx_reg];
            end
        end
    end

    // ---------------------------------------------------------------
    // Update: pick the frame, age the others, load the page
    // ---------------------------------------------------------------
    always_comb begin
        is_fault = !hit_reg;
        evict    = !hit_reg && !empty_reg;
        age_all  = !hit_reg && empty_reg;
        priority if (hit_reg) begin
            f_idx  = hit_idx_reg;
            f_rank = hit_rank_reg;
        end else if (empty_reg) begin
            f_idx  = empty_idx_reg;
            f_rank = lru_rank_reg;   // unused when filling an empty frame
        end else begin
            f_idx  = lru_idx_reg;
            f_rank = lru_rank_reg;
        end
    end

    always_comb begin
        valid_next       = valid_reg;
        fault_total_next = fault_total_reg;
        for (int i = 0; i < FRAMES; i++) begin
            rank_next[i] = rank_reg[i];
            if (commit) begin
                if (FRAME_IDX_W'(i) == f_idx) begin
                    rank_next[i] = '0;
                end else if (valid_reg[i] && (age_all || (rank_reg[i] < f_rank))) begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
        end
        if (commit && is_fault) begin
            valid_next[f_idx] = 1'b1;
            if (fault_total_reg != '1) begin
                fault_total_next = fault_total_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            fault_total_reg <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg       <= valid_next;
            fault_total_reg <= fault_total_next;
            for (int i = 0; i < FRAMES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit && is_fault) begin
            page_mem[f_idx] <= page_reg;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_fault_reg    <= is_fault;
            out_idx_reg      <= f_idx;
            out_ev_valid_reg <= evict;
            out_ev_page_reg  <= evict ? lru_page_reg : '0;
            out_count_reg    <= fault_total_next;
            out_last_reg     <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_count_reg, out_ev_page_reg,
                                    out_ev_valid_reg, out_idx_reg});
    assign m_tuser  = out_fault_reg;
    assign m_tlast  = out_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `LRUPR_ASSERT_NXT(a_valid_sticky, aclk, aresetn, aresetn,
        (valid_reg & $past(valid_reg)) == $past(valid_reg), "frame lost its valid bit")
    `LRUPR_ASSERT_NXT(a_count_mono, aclk, aresetn, aresetn,
        fault_total_reg >= $past(fault_total_reg), "fault count went down")
    `LRUPR_ASSERT_IMP(a_scan_bound, aclk, aresetn, state_reg == ST_SCAN,
        idx_reg <= last_idx, "scan ran past the active frames")
    `LRUPR_ASSERT_IMP(a_hit_no_evict, aclk, aresetn, out_valid_reg && !out_fault_reg,
        !out_ev_valid_reg && (out_ev_page_reg == '0), "hit reported an eviction")
    `LRUPR_ASSERT_IMP(a_fault_counted, aclk, aresetn, out_valid_reg && out_fault_reg,
        out_count_reg != '0, "fault with zero fault count")

endmodule
